/* sv/pfbcf_pkg.sv */
// Shared constants, command types and inter-module structs for the page framebuffer circle fill.
package pfbcf_pkg;

  // Display geometry and limits
  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 48;
  localparam int MAX_RADIUS     = 31;

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
  // signed offset width, -r .. r
  localparam int DW          = RAD_W + 1;
  // signed pixel coordinate width, center plus offset plus compare headroom
  localparam int CO_W        = ((DW > 8) ? DW : 8) + 2;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] BYTE_BLACK = 8'h00;
  localparam logic [7:0] BYTE_WHITE = 8'hFF;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_FILL   = 2'd1,
    OP_CIRCLE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // classified command as held in the queue
  typedef struct packed {
    op_e                op;
    logic signed [7:0]  cx;
    logic signed [7:0]  cy;
    logic [RAD_W-1:0]   radius;   // already saturated
    logic               pixel_on;
    logic [ADDR_W-1:0]  addr;
    logic               addr_ok;  // read index lies inside the store
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // back-end status toward the front end
  typedef struct packed {
    logic init;   // reset clearing pass running
    logic pop;    // head command taken this cycle
  } bk_stat_t;

endpackage

/* sv/pfbcf_front.sv */
// Command front end: accepts commands, classifies them and queues them for the back end.
module pfbcf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [1:0]                op_i,
  input  logic signed [7:0]         center_x_i,
  input  logic signed [7:0]         center_y_i,
  input  logic [4:0]                radius_i,
  input  logic                      pixel_on_i,
  input  logic [8:0]                byte_index_i,
  input  pfbcf_pkg::bk_stat_t       stat_i,
  output logic                      busy_o,
  output pfbcf_pkg::q_head_t        head_o
);

  pfbcf_pkg::cmd_t                   cmd_in;
  pfbcf_pkg::cmd_t                   fifo_q [pfbcf_pkg::QDEPTH];
  logic [pfbcf_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pfbcf_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pfbcf_pkg::QPTR_W:0]        cnt_q, cnt_d;
  logic                              full;
  logic                              push;
  logic                              pop;

  // classify the incoming command: saturate radius, range-check read index
  always_comb begin
    cmd_in          = '0;
    cmd_in.op       = pfbcf_pkg::op_e'(op_i);
    cmd_in.cx       = center_x_i;
    cmd_in.cy       = center_y_i;
    cmd_in.pixel_on = pixel_on_i;
    if (32'(radius_i) > pfbcf_pkg::MAX_RADIUS) begin
      cmd_in.radius = pfbcf_pkg::RAD_W'(pfbcf_pkg::MAX_RADIUS);
    end else begin
      cmd_in.radius = pfbcf_pkg::RAD_W'(radius_i);
    end
    cmd_in.addr_ok  = (32'(byte_index_i) < pfbcf_pkg::STORE_BYTES);
    cmd_in.addr     = pfbcf_pkg::ADDR_W'(byte_index_i);
  end

  // queue control
  assign full   = (cnt_q == (pfbcf_pkg::QPTR_W + 1)'(pfbcf_pkg::QDEPTH));
  assign busy_o = full || stat_i.init;
  assign push   = start_i && !busy_o;
  assign pop    = stat_i.pop;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pfbcf_pkg::QPTR_W'(pfbcf_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pfbcf_pkg::QPTR_W'(pfbcf_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* sv/pfbcf_back.sv */
// Command back end: frame store, clear/fill sweep, pipelined circle read-modify-write, byte read.
module pfbcf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfbcf_pkg::q_head_t    head_i,
  output pfbcf_pkg::bk_stat_t   stat_o,
  output logic                  read_valid_o,
  output logic [7:0]            read_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_CIRCLE,
    S_READ
  } state_e;

  localparam int AW = pfbcf_pkg::ADDR_W;
  localparam int DW = pfbcf_pkg::DW;
  localparam int CW = pfbcf_pkg::CO_W;
  localparam int RW = pfbcf_pkg::RAD_W;

  // frame store
  logic [7:0]                mem_q [pfbcf_pkg::STORE_BYTES];
  logic [7:0]                rdata_q;
  logic [AW-1:0]             rd_addr;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [7:0]                wd;

  // control
  state_e                    state_q, state_d;
  logic                      init_q, init_d;
  logic [AW-1:0]             sweep_cnt_q, sweep_cnt_d;
  logic [7:0]                sweep_data_q, sweep_data_d;
  logic                      read_valid_q, read_valid_d;
  logic                      b_vld_q, b_vld_d;
  logic                      fwd_vld_q;
  logic                      pop;
  logic                      load;
  logic                      step;
  logic                      last_pt;

  // circle job payload
  logic signed [7:0]         cx_q, cy_q;
  logic [RW-1:0]             r_q;
  logic                      on_q;
  logic [2*RW-1:0]           r2_q;
  logic signed [DW-1:0]      dx_q, dy_q;
  logic signed [DW-1:0]      r_s;
  logic                      rd_ok_q;
  logic [7:0]                read_data_q, read_data_d;

  // pixel pipeline, write stage and forwarding
  logic [AW-1:0]             b_addr_q;
  logic [7:0]                b_mask_q;
  logic                      b_on_q;
  logic [AW-1:0]             fwd_addr_q;
  logic [7:0]                fwd_data_q;
  logic [7:0]                base;

  // point test signals
  logic signed [2*DW-1:0]    dx2, dy2;
  logic [2*DW:0]             dist_sq;
  logic signed [CW-1:0]      px, py;
  logic [CW-1:0]             px_u, py_u;
  logic                      on_disc, on_screen, hit;
  logic [AW-1:0]             pix_addr;
  logic [7:0]                pix_mask;
  logic signed [DW-1:0]      head_r_s;

  assign r_s      = DW'(signed'({1'b0, r_q}));
  assign head_r_s = DW'(signed'({1'b0, head_i.cmd.radius}));

  // point under test: inside the disc and on the display
  always_comb begin
    dx2       = dx_q * dx_q;
    dy2       = dy_q * dy_q;
    dist_sq   = (2*DW+1)'($unsigned(dx2)) + (2*DW+1)'($unsigned(dy2));
    on_disc   = (dist_sq <= (2*DW+1)'(r2_q));
    px        = CW'(cx_q) + CW'(dx_q);
    py        = CW'(cy_q) + CW'(dy_q);
    px_u      = px;
    py_u      = py;
    on_screen = !px[CW-1] && (px < CW'(pfbcf_pkg::DISPLAY_WIDTH)) &&
                !py[CW-1] && (py < CW'(pfbcf_pkg::DISPLAY_HEIGHT));
    hit       = on_disc && on_screen;
    pix_addr  = AW'(32'(py_u[CW-1:3]) * pfbcf_pkg::DISPLAY_WIDTH + 32'(px_u));
    pix_mask  = 8'd1 << py_u[2:0];
    last_pt   = (dx_q == r_s) && (dy_q == r_s);
  end

  // write stage: merge mask into the byte, forwarding last cycle's write
  always_comb begin
    base = (fwd_vld_q && (fwd_addr_q == b_addr_q)) ? fwd_data_q : rdata_q;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    sweep_cnt_d  = sweep_cnt_q;
    sweep_data_d = sweep_data_q;
    read_valid_d = 1'b0;
    read_data_d  = read_data_q;
    b_vld_d      = 1'b0;
    pop          = 1'b0;
    load         = 1'b0;
    step         = 1'b0;
    rd_addr      = head_i.cmd.addr;
    we           = b_vld_q;
    wa           = b_addr_q;
    wd           = b_on_q ? (base | b_mask_q) : (base & ~b_mask_q);

    case (state_q)
      S_IDLE: begin
        if (head_i.valid && !b_vld_q) begin
          pop  = 1'b1;
          load = 1'b1;
          case (head_i.cmd.op)
            pfbcf_pkg::OP_CLEAR: begin
              state_d      = S_SWEEP;
              sweep_cnt_d  = '0;
              sweep_data_d = pfbcf_pkg::BYTE_BLACK;
            end
            pfbcf_pkg::OP_FILL: begin
              state_d      = S_SWEEP;
              sweep_cnt_d  = '0;
              sweep_data_d = pfbcf_pkg::BYTE_WHITE;
            end
            pfbcf_pkg::OP_CIRCLE: begin
              state_d = S_CIRCLE;
            end
            pfbcf_pkg::OP_READ: begin
              state_d = S_READ;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SWEEP: begin
        we = 1'b1;
        wa = sweep_cnt_q;
        wd = sweep_data_q;
        if (sweep_cnt_q == AW'(pfbcf_pkg::STORE_BYTES - 1)) begin
          state_d = S_IDLE;
          init_d  = 1'b0;
        end else begin
          sweep_cnt_d = sweep_cnt_q + 1'b1;
        end
      end
      S_CIRCLE: begin
        step    = 1'b1;
        rd_addr = pix_addr;
        b_vld_d = hit;
        if (last_pt) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        read_valid_d = 1'b1;
        read_data_d  = rd_ok_q ? rdata_q : pfbcf_pkg::BYTE_BLACK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      init_q       <= 1'b1;
      sweep_cnt_q  <= '0;
      sweep_data_q <= pfbcf_pkg::BYTE_BLACK;
      read_valid_q <= 1'b0;
      b_vld_q      <= 1'b0;
      fwd_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      sweep_cnt_q  <= sweep_cnt_d;
      sweep_data_q <= sweep_data_d;
      read_valid_q <= read_valid_d;
      b_vld_q      <= b_vld_d;
      fwd_vld_q    <= we;
    end
  end

  // job payload, scan counters and pipeline data
  always_ff @(posedge clk_i) begin
    read_data_q <= read_data_d;
    fwd_addr_q  <= wa;
    fwd_data_q  <= wd;
    b_addr_q    <= pix_addr;
    b_mask_q    <= pix_mask;
    b_on_q      <= on_q;
    if (load) begin
      cx_q    <= head_i.cmd.cx;
      cy_q    <= head_i.cmd.cy;
      r_q     <= head_i.cmd.radius;
      on_q    <= head_i.cmd.pixel_on;
      r2_q    <= head_i.cmd.radius * head_i.cmd.radius;
      rd_ok_q <= head_i.cmd.addr_ok;
      dx_q    <= -head_r_s;
      dy_q    <= -head_r_s;
    end else if (step) begin
      if (dx_q == r_s) begin
        dx_q <= -r_s;
        dy_q <= dy_q + DW'(1);
      end else begin
        dx_q <= dx_q + DW'(1);
      end
    end
  end

  // frame store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign stat_o.init  = init_q;
  assign stat_o.pop   = pop;
  assign read_valid_o = read_valid_q;
  assign read_data_o  = read_data_q;

endmodule

/* sv/page_framebuffer_circle_fill_unit.sv */
// Top level of the monochrome page framebuffer with clear, fill, filled circle and byte read.
//
// Usage: a command is transferred when start_i is high and busy_o is low.
// op_i selects clear, fill, filled circle or byte read; the other fields are
// sampled with it and queued (two deep), so busy_o only rises when the queue
// is full or the store is being cleared after reset.
// Only a read gives a result: read_valid_o pulses for one cycle with
// read_data_o, and the receiver must take it then. Out-of-range reads give 0.
// Commands run one at a time in arrival order in the back end.
// Work per command in the back end, which has a single store write port:
//   clear / fill : all 384 bytes, one byte written per cycle
//   circle       : every point of the (2r+1)^2 square, one point tested and
//                  merged per cycle; the pixel read-modify-write is pipelined
//                  with forwarding
//   read         : a registered store read, then the registered result strobe
// After reset all 384 store bytes are swept to black; busy_o stays high
// until that pass ends.
module page_framebuffer_circle_fill_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic signed [7:0]  center_x_i,
  input  logic signed [7:0]  center_y_i,
  input  logic [4:0]         radius_i,
  input  logic               pixel_on_i,
  input  logic [8:0]         byte_index_i,
  output logic               read_valid_o,
  output logic [7:0]         read_data_o
);

  pfbcf_pkg::q_head_t  head;
  pfbcf_pkg::bk_stat_t stat;

  // command intake and queue
  pfbcf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .pixel_on_i   (pixel_on_i),
    .byte_index_i (byte_index_i),
    .stat_i       (stat),
    .busy_o       (busy_o),
    .head_o       (head)
  );

  // execution and frame store
  pfbcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .stat_o       (stat),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o)
  );

endmodule

/* dv/framebuffer_checker.sv */
// Checker for the page framebuffer: mirrors the pixel store and compares every read result.
`timescale 1ns / 1ps
module framebuffer_checker
  import pfbcf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        op_i,
  input  logic signed [7:0] center_x_i,
  input  logic signed [7:0] center_y_i,
  input  logic [4:0]        radius_i,
  input  logic              pixel_on_i,
  input  logic [8:0]        byte_index_i,
  input  logic              read_valid_i,
  input  logic [7:0]        read_data_i,
  output int                mismatch_count_o,
  output int                reads_due_o,
  output int                reads_checked_o
);

  // mirror of the frame store, one byte per column per page
  logic [7:0] pix_store [STORE_BYTES];
  // bytes that outstanding reads must return, oldest first
  logic [7:0] read_bytes_due [$];
  logic [7:0] due_byte;

  int mismatches = 0;
  int due_count  = 0;
  int checked    = 0;

  assign mismatch_count_o = mismatches;
  assign reads_due_o      = due_count;
  assign reads_checked_o  = checked;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // set or clear every on-screen pixel within the disc, off-screen points are dropped
  task automatic paint_disc(input int cx, input int cy, input int rad, input logic on);
    int dx;
    int dy;
    int px;
    int py;
    int idx;
    for (dy = -rad; dy <= rad; dy++) begin
      for (dx = -rad; dx <= rad; dx++) begin
        px = cx + dx;
        py = cy + dy;
        if (dx * dx + dy * dy <= rad * rad && px >= 0 && px < DISPLAY_WIDTH &&
            py >= 0 && py < DISPLAY_HEIGHT) begin
          idx = (py / 8) * DISPLAY_WIDTH + px;
          pix_store[idx][py % 8] = on;
        end
      end
    end
  endtask

  // update the mirror for one accepted command, queue a byte for each read
  task automatic apply_command();
    int rad;
    case (op_e'(op_i))
      OP_CLEAR: begin
        foreach (pix_store[i]) pix_store[i] = BYTE_BLACK;
      end
      OP_FILL: begin
        foreach (pix_store[i]) pix_store[i] = BYTE_WHITE;
      end
      OP_CIRCLE: begin
        rad = radius_i;
        if (rad > MAX_RADIUS) rad = MAX_RADIUS;
        paint_disc(center_x_i, center_y_i, rad, pixel_on_i);
      end
      OP_READ: begin
        // reads past the store return zero
        read_bytes_due.push_back((byte_index_i < STORE_BYTES) ? pix_store[byte_index_i] : '0);
        due_count++;
      end
      default: report_mismatch("command accepted with unknown op");
    endcase
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pix_store[i]) pix_store[i] = BYTE_BLACK;
      read_bytes_due.delete();
      due_count = 0;
    end else begin
      // result transfer
      if (read_valid_i) begin
        if (read_bytes_due.size() == 0) begin
          report_mismatch($sformatf("read_data 0x%02h with no read outstanding", read_data_i));
        end else begin
          due_byte = read_bytes_due.pop_front();
          due_count--;
          checked++;
          if (read_data_i !== due_byte)
            report_mismatch($sformatf("read_data 0x%02h, predicted 0x%02h",
                                      read_data_i, due_byte));
        end
      end
      // command transfer
      if (start_i && !busy_i) apply_command();
    end
  end

endmodule

/* dv/testbench.sv */
// Top of the framebuffer testbench: clock, reset, command stimulus and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import pfbcf_pkg::*;

  localparam int     CLK_PERIOD   = 8;
  localparam int     N_ITEMS      = 1150;
  // up to three queued largest circles may still run after the last read
  localparam int     DRAIN_CYCLES = 12500;
  localparam longint RUN_LIMIT    = 64'd20_000_000;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start_i      = 1'b0;
  logic [1:0]        op_i         = OP_CLEAR;
  logic signed [7:0] center_x_i   = '0;
  logic signed [7:0] center_y_i   = '0;
  logic [4:0]        radius_i     = '0;
  logic              pixel_on_i   = 1'b0;
  logic [8:0]        byte_index_i = '0;
  logic              busy_o;
  logic              read_valid_o;
  logic [7:0]        read_data_o;

  int     fail_count;
  int     reads_due;
  int     reads_checked;
  longint cycle_cnt = 0;
  int     n_sent    = 0;
  int     op_seen [4] = '{0, 0, 0, 0};
  bit     burst     = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always_ff @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  page_framebuffer_circle_fill_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .pixel_on_i   (pixel_on_i),
    .byte_index_i (byte_index_i),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o)
  );

  framebuffer_checker u_fb_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .op_i             (op_i),
    .center_x_i       (center_x_i),
    .center_y_i       (center_y_i),
    .radius_i         (radius_i),
    .pixel_on_i       (pixel_on_i),
    .byte_index_i     (byte_index_i),
    .read_valid_i     (read_valid_o),
    .read_data_i      (read_data_o),
    .mismatch_count_o (fail_count),
    .reads_due_o      (reads_due),
    .reads_checked_o  (reads_checked)
  );

  // idle cycles before the next command, none inside a burst
  function automatic int pick_gap();
    return burst ? 0 : int'($urandom_range(0, 11));
  endfunction

  // a byte index around a disc, or anywhere when the point falls off screen
  function automatic logic [8:0] near_index(input int cx, input int cy, input int rad);
    int px;
    int py;
    px = cx + int'($urandom_range(0, 2 * rad + 2)) - rad - 1;
    py = cy + int'($urandom_range(0, 2 * rad + 2)) - rad - 1;
    if (px < 0 || px >= DISPLAY_WIDTH || py < 0 || py >= DISPLAY_HEIGHT)
      return 9'($urandom_range(0, 511));
    return 9'((py / 8) * DISPLAY_WIDTH + px);
  endfunction

  // present one command at this edge and hold it until its transfer
  task automatic send_cmd(input op_e op, input logic signed [7:0] cx,
                          input logic signed [7:0] cy, input logic [4:0] rad,
                          input logic on, input logic [8:0] idx);
    int gap;
    gap          = pick_gap();
    op_i         <= op;
    center_x_i   <= cx;
    center_y_i   <= cy;
    radius_i     <= rad;
    pixel_on_i   <= on;
    byte_index_i <= idx;
    start_i      <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    n_sent++;
    op_seen[op]++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // circle with random don't-care read index
  task automatic send_disc(input logic signed [7:0] cx, input logic signed [7:0] cy,
                           input logic [4:0] rad, input logic on);
    send_cmd(OP_CIRCLE, cx, cy, rad, on, 9'($urandom_range(0, 511)));
  endtask

  // read with random don't-care circle fields
  task automatic send_read(input logic [8:0] idx);
    send_cmd(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             5'($urandom_range(0, 31)), 1'($urandom), idx);
  endtask

  // clear or fill with random don't-care fields
  task automatic send_flood(input op_e op);
    send_cmd(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             5'($urandom_range(0, 31)), 1'($urandom), 9'($urandom_range(0, 511)));
  endtask

  // timeout guard
  initial begin
    while (cycle_cnt < RUN_LIMIT) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic signed [7:0] cx8;
    logic signed [7:0] cy8;
    logic [4:0]        rad;
    int                kind;
    int                n_follow;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: store after reset, out-of-range reads, fill, clipping, extremes
    send_read(9'd0);
    send_read(9'd383);
    send_read(9'd384);
    send_read(9'd511);
    send_flood(OP_FILL);
    send_read(9'd0);
    send_read(9'd383);
    send_disc(8'sd0, 8'sd0, 5'd0, 1'b0);
    send_read(9'd0);
    send_flood(OP_CLEAR);
    send_disc(8'sd31, 8'sd23, 5'd31, 1'b1);
    send_read(9'd0);
    send_read(9'd383);
    send_disc(8'sd127, 8'sd127, 5'd31, 1'b1);
    send_disc(-8'sd128, -8'sd128, 5'd31, 1'b0);
    send_disc(-8'sd1, -8'sd1, 5'd2, 1'b0);
    send_read(9'd0);
    send_disc(8'sd63, 8'sd47, 5'd0, 1'b0);
    send_read(9'd383);
    send_disc(8'sd64, 8'sd20, 5'd3, 1'b0);
    send_read(9'd127);
    send_disc(8'sd20, 8'sd48, 5'd5, 1'b0);
    send_read(9'd340);

    // random: mostly a disc followed by reads around it, some floods, some noise
    while (n_sent < N_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 9);
      if (kind < 6) begin
        cx8 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'(int'($urandom_range(0, 83)) - 10);
        cy8 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'(int'($urandom_range(0, 67)) - 10);
        rad = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 8));
        send_disc(cx8, cy8, rad, 1'($urandom));
        n_follow = $urandom_range(1, 4);
        repeat (n_follow) send_read(near_index(cx8, cy8, rad));
      end else if (kind == 6) begin
        send_flood(($urandom_range(0, 1) == 0) ? OP_CLEAR : OP_FILL);
        n_follow = $urandom_range(1, 2);
        repeat (n_follow) send_read(9'($urandom_range(0, STORE_BYTES - 1)));
      end else begin
        n_follow = $urandom_range(1, 3);
        repeat (n_follow)
          send_cmd(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                   1'($urandom), 9'($urandom_range(0, 511)));
      end
    end
    start_i <= 1'b0;

    // drain outstanding reads, then let trailing commands finish
    do @(negedge clk_i); while (reads_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d commands transferred (%0d clear, %0d fill, %0d circle, %0d read)",
             n_sent, op_seen[OP_CLEAR], op_seen[OP_FILL], op_seen[OP_CIRCLE],
             op_seen[OP_READ]);
    $display("run: %0d read bytes compared, %0d mismatches", reads_checked, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
